>>> hdl/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// shared types, constants and saturating helpers of the smooth damp follower
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

  localparam int FRAC_BITS = 16;

  typedef logic signed [63:0] val_t;

  // saturation bound of all intermediates
  localparam val_t LIM = val_t'(64'h2000_0000_0000_0000);
  localparam val_t ONE = val_t'(64'sd1 <<< FRAC_BITS);
  localparam val_t C048 = val_t'(((64'sd48 <<< FRAC_BITS) + 64'sd50) / 64'sd100);
  localparam val_t C0235 = val_t'(((64'sd235 <<< FRAC_BITS) + 64'sd500) / 64'sd1000);
  localparam val_t INT32_MAX_V = val_t'(64'sd2147483647);
  localparam val_t INT32_MIN_V = -val_t'(64'sd2147483648);

  // settle time floor, never below one lsb
  localparam int ST_MIN_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
  localparam int ST_MIN = (ST_MIN_RAW < 1) ? 1 : ST_MIN_RAW;
  localparam logic [30:0] ST_MIN_W = 31'(ST_MIN);

  // numerators of the two divisions
  localparam val_t NUM_OMEGA = val_t'(64'sd2 <<< (2 * FRAC_BITS));
  localparam val_t NUM_DECAY = val_t'(64'sd1 <<< (2 * FRAC_BITS));

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_CAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 2'd2;

  localparam logic [30:0] SETTLE_TIME_RST = 31'd65536;
  localparam logic [30:0] SPEED_CAP_RST = 31'h7FFF_FFFF;
  localparam logic [16:0] TICK_PERIOD_RST = 17'd1092;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  function automatic val_t clamp_lim(val_t a);
    val_t r;
    if (a > LIM) r = LIM;
    else if (a < -LIM) r = -LIM;
    else r = a;
    return r;
  endfunction

  function automatic val_t sadd(val_t a, val_t b);
    val_t s;
    s = clamp_lim(a) + clamp_lim(b);
    return clamp_lim(s);
  endfunction

  function automatic logic signed [31:0] sat32(val_t a);
    val_t r;
    if (a > INT32_MAX_V) r = INT32_MAX_V;
    else if (a < INT32_MIN_V) r = INT32_MIN_V;
    else r = a;
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/sdf_alu.sv
// ----------------------------------------------------------------------------
// sdf_alu
// shared multi-cycle unit: rounded saturating fixed point multiply and
// restoring unsigned division
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_alu (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sdf_pkg::alu_req_t req_i,
  input  sdf_pkg::val_t    a_i,
  input  sdf_pkg::val_t    b_i,
  output sdf_pkg::alu_rsp_t rsp_o,
  output sdf_pkg::val_t    res_o
);
  import sdf_pkg::*;

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_MUL  = 2'd1;
  localparam logic [1:0] A_MFIN = 2'd2;
  localparam logic [1:0] A_DIV  = 2'd3;

  logic [1:0]   state_q, state_d;
  logic [5:0]   cnt_q, cnt_d;
  logic         neg_q, neg_d;
  logic [61:0]  ua_q, ua_d;
  logic [61:0]  ub_q, ub_d;
  logic [63:0]  num_q, num_d;
  logic [61:0]  rem_q, rem_d;
  logic [123:0] acc_q, acc_d;
  val_t         res_q, res_d;
  logic         done_q, done_d;

  val_t         ca, cb;
  logic [30:0]  la, lb;
  logic [61:0]  pp;
  logic [123:0] pp_sh;
  logic [62:0]  rem_sh;
  logic         ge;
  logic [63:0]  q;

  always_comb begin
    ca = clamp_lim(a_i);
    cb = clamp_lim(b_i);
    la = cnt_q[1] ? ua_q[61:31] : ua_q[30:0];
    lb = cnt_q[0] ? ub_q[61:31] : ub_q[30:0];
    pp = 62'(la) * 62'(lb);
    case ({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]})
      2'd0:    pp_sh = {62'b0, pp};
      2'd1:    pp_sh = {31'b0, pp, 31'b0};
      default: pp_sh = {pp, 62'b0};
    endcase
    rem_sh = {rem_q, num_q[63]};
    ge = rem_sh >= {1'b0, ub_q};
    // rounding: half an lsb or more rounds the magnitude up
    if (|acc_q[123:64]) begin
      q = 64'(LIM);
    end else begin
      q = (acc_q[63:0] >> FRAC_BITS) + 64'(acc_q[FRAC_BITS-1]);
      if (q > 64'(LIM)) q = 64'(LIM);
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    ua_d    = ua_q;
    ub_d    = ub_q;
    num_d   = num_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          cnt_d = '0;
          if (req_i.op == ALU_MUL) begin
            neg_d   = ca[63] ^ cb[63];
            ua_d    = ca[63] ? 62'(-ca) : ca[61:0];
            ub_d    = cb[63] ? 62'(-cb) : cb[61:0];
            acc_d   = '0;
            state_d = A_MUL;
          end else begin
            num_d   = a_i;
            ub_d    = b_i[61:0];
            rem_d   = '0;
            cnt_d   = 6'd63;
            state_d = A_DIV;
          end
        end
      end
      A_MUL: begin
        acc_d = acc_q + pp_sh;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q[1:0] == 2'd3) state_d = A_MFIN;
      end
      A_MFIN: begin
        res_d   = neg_q ? -val_t'(q) : val_t'(q);
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      A_DIV: begin
        rem_d = ge ? 62'(rem_sh - {1'b0, ub_q}) : rem_sh[61:0];
        num_d = {num_q[62:0], ge};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          res_d   = {num_q[62:0], ge};
          done_d  = 1'b1;
          state_d = A_IDLE;
        end
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    ua_q  <= ua_d;
    ub_q  <= ub_d;
    num_q <= num_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign rsp_o.busy = (state_q != A_IDLE);
  assign rsp_o.done = done_q;
  assign res_o      = res_q;

endmodule

`default_nettype wire

>>> hdl/smooth_damp_follower.sv
// ----------------------------------------------------------------------------
// smooth_damp_follower
// scalar critically damped follower: per transaction steps a position toward
// a target with a kept velocity, all values signed fixed point
// ----------------------------------------------------------------------------
//
//  channel   direction  payload
//  s_axis    in         tdata: current_pos, target_pos
//  m_axis    out        tdata: new_pos, new_velocity; tuser: snapped
//  cfg       in         index + data: settle time, speed cap, tick_period
//
//  one transaction runs two divisions with 64-bit quotients (omega and the
//  decay factor) and eleven products, all on the one shared alu
//  s_axis_tready and cfg_ready_o are high only while the sequencer is idle;
//  an offered register write takes precedence over a new transaction
//  the result sits in an output register, so the next transaction is taken
//  while it waits; a stalled result holds the sequencer at its last step
//  reset clears the velocity and loads the register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module smooth_damp_follower (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] current_pos, [63:32] target_pos
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] new_pos, [63:32] new_velocity
  output logic        m_axis_tuser,   // [0] snapped
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [sdf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import sdf_pkg::*;

  // sequencer steps, one alu operation each except IDLE, DEN and OUT
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_OMEGA = 4'd1;
  localparam logic [3:0] ST_X     = 4'd2;
  localparam logic [3:0] ST_X2    = 4'd3;
  localparam logic [3:0] ST_X3    = 4'd4;
  localparam logic [3:0] ST_T48   = 4'd5;
  localparam logic [3:0] ST_T235  = 4'd6;
  localparam logic [3:0] ST_DEN   = 4'd7;
  localparam logic [3:0] ST_EX    = 4'd8;
  localparam logic [3:0] ST_MAXC  = 4'd9;
  localparam logic [3:0] ST_OMC   = 4'd10;
  localparam logic [3:0] ST_TEMP  = 4'd11;
  localparam logic [3:0] ST_OMT   = 4'd12;
  localparam logic [3:0] ST_NV    = 4'd13;
  localparam logic [3:0] ST_RES   = 4'd14;
  localparam logic [3:0] ST_OUT   = 4'd15;

  logic [3:0]  state_q, state_d;

  // configuration registers
  logic [30:0] settle_time_q, speed_cap_q;
  logic [16:0] tick_period_q;

  // per transaction working registers
  logic [30:0]        st_q;
  logic signed [31:0] cur_q, tgt_q;
  logic signed [31:0] vel_q, vel_d;
  val_t omega_q, x_q, x2_q, x3_q, den_q, ex_q, chg_q, base_q, tmp_q, acc_q, nv_q, res_q;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_data_q;
  logic        out_user_q;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  val_t     alu_a, alu_b, alu_res;

  logic accept_in, op_step, out_load, snap;
  val_t maxc, diff, chg;
  logic signed [31:0] pos_o, nvel_o;

  assign accept_in     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == ST_IDLE);

  // steps that run an alu operation
  assign op_step = !(state_q inside {ST_IDLE, ST_DEN, ST_OUT});

  // operand selection per step
  always_comb begin
    alu_req.start = op_step && !alu_rsp.busy && !alu_rsp.done;
    alu_req.op = ALU_MUL;
    alu_a = '0;
    alu_b = '0;
    case (state_q)
      ST_OMEGA: begin
        alu_req.op = ALU_DIV;
        alu_a = NUM_OMEGA + val_t'({34'b0, st_q[30:1]});
        alu_b = val_t'({33'b0, st_q});
      end
      ST_X: begin
        alu_a = omega_q;
        alu_b = val_t'({47'b0, tick_period_q});
      end
      ST_X2: begin
        alu_a = x_q;
        alu_b = x_q;
      end
      ST_X3: begin
        alu_a = x2_q;
        alu_b = x_q;
      end
      ST_T48: begin
        alu_a = C048;
        alu_b = x2_q;
      end
      ST_T235: begin
        alu_a = C0235;
        alu_b = x3_q;
      end
      ST_EX: begin
        alu_req.op = ALU_DIV;
        alu_a = NUM_DECAY + (den_q >>> 1);
        alu_b = den_q;
      end
      ST_MAXC: begin
        alu_a = val_t'({33'b0, speed_cap_q});
        alu_b = val_t'({33'b0, st_q});
      end
      ST_OMC: begin
        alu_a = omega_q;
        alu_b = chg_q;
      end
      ST_TEMP: begin
        alu_a = acc_q;
        alu_b = val_t'({47'b0, tick_period_q});
      end
      ST_OMT: begin
        alu_a = omega_q;
        alu_b = tmp_q;
      end
      ST_NV, ST_RES: begin
        alu_a = acc_q;
        alu_b = ex_q;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  sdf_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res)
  );

  // change limit: speed cap times settle time, capped at int32 max
  always_comb begin
    maxc = (alu_res > INT32_MAX_V) ? INT32_MAX_V : alu_res;
    diff = val_t'(cur_q) - val_t'(tgt_q);
    if (diff > maxc) chg = maxc;
    else if (diff < -maxc) chg = -maxc;
    else chg = diff;
  end

  // overshoot guard and final saturation
  always_comb begin
    snap   = ((val_t'(tgt_q) - val_t'(cur_q)) > 0) == (res_q > val_t'(tgt_q));
    pos_o  = snap ? tgt_q : sat32(res_q);
    nvel_o = snap ? 32'sd0 : sat32(nv_q);
  end

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    vel_d   = vel_q;
    case (state_q)
      ST_IDLE:  if (accept_in) state_d = ST_OMEGA;
      ST_DEN:   state_d = ST_EX;
      ST_OUT: begin
        if (out_load) begin
          vel_d   = nvel_o;
          state_d = ST_IDLE;
        end
      end
      default: begin
        if (alu_rsp.done) state_d = state_q + 4'd1;
      end
    endcase
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      vel_q         <= '0;
      out_valid_q   <= 1'b0;
      settle_time_q <= SETTLE_TIME_RST;
      speed_cap_q   <= SPEED_CAP_RST;
      tick_period_q <= TICK_PERIOD_RST;
    end else begin
      state_q     <= state_d;
      vel_q       <= vel_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_SETTLE_TIME: settle_time_q <= cfg_data_i[30:0];
          REG_SPEED_CAP:   speed_cap_q   <= cfg_data_i[30:0];
          REG_TICK_PERIOD: tick_period_q <= cfg_data_i[16:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers, loaded on acceptance and as each step completes
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      cur_q <= s_axis_tdata[31:0];
      tgt_q <= s_axis_tdata[63:32];
      st_q  <= (settle_time_q < ST_MIN_W) ? ST_MIN_W : settle_time_q;
    end
    if (state_q == ST_DEN) begin
      den_q <= sadd(sadd(ONE, x_q), sadd(x2_q, x3_q));
    end
    if (alu_rsp.done) begin
      case (state_q)
        ST_OMEGA: omega_q <= alu_res;
        ST_X:     x_q     <= alu_res;
        ST_X2:    x2_q    <= alu_res;
        ST_X3:    x3_q    <= alu_res;
        ST_T48:   x2_q    <= alu_res;   // x^2 no longer needed
        ST_T235:  x3_q    <= alu_res;
        ST_EX:    ex_q    <= alu_res;
        ST_MAXC: begin
          chg_q  <= chg;
          base_q <= val_t'(cur_q) - chg;
        end
        ST_OMC:   acc_q   <= sadd(val_t'(vel_q), alu_res);
        ST_TEMP:  tmp_q   <= alu_res;
        ST_OMT:   acc_q   <= sadd(val_t'(vel_q), -alu_res);
        ST_NV: begin
          nv_q  <= alu_res;
          acc_q <= sadd(chg_q, tmp_q);
        end
        ST_RES:   res_q   <= sadd(base_q, alu_res);
        default: ;
      endcase
    end
    if (out_load) begin
      out_data_q <= {nvel_o, pos_o};
      out_user_q <= snap;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // a new transaction always starts with the omega division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> (state_q == ST_OMEGA))
    else $error("sequencer did not start on accepted transaction");

  // the alu is never started while it still works
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> !alu_rsp.busy)
    else $error("alu started while busy");

  // a snapped result carries zero velocity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[63:32] == 32'd0))
    else $error("snapped result with nonzero velocity");

  // the velocity changes only when a result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_load |=> $stable(vel_q))
    else $error("velocity changed outside result load");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of the smooth damp follower: a fixed-point predictor
// tracks the kept velocity and the registers, each result is compared field
// by field, stimulus is directed corner cases, output stalls and random follow sequences
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sdf_pkg::*;

  localparam int LATENCY = 260;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               snap;
  } step_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;    // [31:0] current_pos, [63:32] target_pos
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // [31:0] new_pos, [63:32] new_velocity
  logic m_axis_tuser;                // [0] snapped
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_SETTLE_TIME;
  logic [31:0] cfg_data_i = '0;

  smooth_damp_follower DUT (.*);

  // predictor state and register copies
  logic [30:0] settle_time_q;
  logic [30:0] speed_cap_q;
  logic [16:0] tick_period_q;
  val_t velocity_q;

  step_out_t pending_steps[$];
  logic [31:0] last_pred_pos = '0;
  int  mismatches = 0;
  int  results_seen = 0;
  int  snaps_seen = 0;
  longint cycles = 0;
  bit  hold_off = 1'b0;     // forces a long receiver stall
  bit  fast_sink = 1'b0;    // receiver never stalls

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // rounded product of two fixed-point values, ties away from zero
  function automatic val_t fx_mul(val_t a, val_t b);
    logic neg;
    logic [63:0] ua, ub, q;
    logic [127:0] p;
    a = clamp_lim(a);
    b = clamp_lim(b);
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = ua * ub;
    if (p[127:64] != 0) q = LIM;
    else begin
      q = (p[63:0] >> FRAC_BITS) + (p[FRAC_BITS-1] ? 64'd1 : 64'd0);
      if (q > LIM) q = LIM;
    end
    return neg ? -val_t'(q) : val_t'(q);
  endfunction

  function automatic step_out_t follow_step(logic signed [31:0] cur_in,
                                            logic signed [31:0] tgt_in);
    val_t cur, tgt, st, dt, omega, x, x2, x3, den, decay;
    val_t change, maxc, base, tmp, nv, res;
    logic [63:0] num;
    logic snap;
    step_out_t r;
    cur = val_t'(cur_in);
    tgt = val_t'(tgt_in);
    st = val_t'(settle_time_q);
    if (st < ST_MIN) st = val_t'(ST_MIN);
    dt = val_t'(tick_period_q);
    num = NUM_OMEGA;
    omega = (num + st / 2) / st;
    x = fx_mul(omega, dt);
    x2 = fx_mul(x, x);
    x3 = fx_mul(x2, x);
    den = sadd(sadd(ONE, x), sadd(fx_mul(C048, x2), fx_mul(C0235, x3)));
    num = NUM_DECAY;
    decay = (num + den / 2) / den;
    change = cur - tgt;
    maxc = fx_mul(val_t'(speed_cap_q), st);
    if (maxc > INT32_MAX_V) maxc = INT32_MAX_V;
    if (change > maxc) change = maxc;
    if (change < -maxc) change = -maxc;
    base = cur - change;
    tmp = fx_mul(sadd(velocity_q, fx_mul(omega, change)), dt);
    nv = fx_mul(sadd(velocity_q, -fx_mul(omega, tmp)), decay);
    res = sadd(base, fx_mul(sadd(change, tmp), decay));
    snap = ((tgt - cur) > 0) == (res > tgt);
    if (snap) begin
      res = tgt;
      nv = '0;
    end
    r.pos = sat32(res);
    r.vel = sat32(nv);
    r.snap = snap;
    velocity_q = val_t'(r.vel);
    return r;
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk_i);
  endtask

  // one input transaction, prediction made at acceptance
  task automatic send_step(logic [31:0] cur, logic [31:0] tgt, bit gaps = 1);
    step_out_t r;
    if (gaps) idle_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {tgt, cur};
    do @(posedge clk_i); while (!s_axis_tready);
    r = follow_step(cur, tgt);
    pending_steps.push_back(r);
    last_pred_pos = r.pos;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_steps.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SETTLE_TIME: settle_time_q = value[30:0];
      REG_SPEED_CAP:   speed_cap_q = value[30:0];
      REG_TICK_PERIOD: tick_period_q = value[16:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] st, logic [31:0] ms, logic [31:0] tp);
    wait_drained();
    write_reg(REG_SETTLE_TIME, st);
    write_reg(REG_SPEED_CAP, ms);
    write_reg(REG_TICK_PERIOD, tp);
  endtask

  // receiver: random stalls, a forced hold-off, or always ready
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (fast_sink) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 9) < 7);
  end

  // result checker
  always @(posedge clk_i) begin
    step_out_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (pending_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        exp_r = pending_steps.pop_front();
        if (exp_r.snap) snaps_seen <= snaps_seen + 1;
        if (m_axis_tdata[31:0] !== exp_r.pos || m_axis_tdata[63:32] !== exp_r.vel ||
            m_axis_tuser !== exp_r.snap) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pos %h/%h vel %h/%h snap %b/%b (exp/act)",
                     exp_r.pos, m_axis_tdata[31:0], exp_r.vel, m_axis_tdata[63:32],
                     exp_r.snap, m_axis_tuser);
        end
      end
    end
  end

  task automatic test_corners();
    send_step(32'h0000_0000, 32'h0000_0000);      // equal positions snap
    send_step(32'h8000_0000, 32'h7FFF_FFFF);
    send_step(32'h7FFF_FFFF, 32'h8000_0000);
    send_step(32'h0001_0000, 32'h0005_0000);
    send_step(32'h0002_0000, 32'h0005_0000);
    send_step(32'hFFFF_FFFF, 32'h0000_0001);
    send_step(32'h1234_5678, 32'hEDCB_A987);
    // change limit: speed cap times settle time saturates, then zero limit
    set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65536);
    send_step(32'h8000_0000, 32'h7FFF_FFFF);
    send_step(32'h0000_0000, 32'h4000_0000);
    set_regs(32'd65536, 32'd0, 32'd1092);
    send_step(32'h0010_0000, 32'hFFF0_0000);
    send_step(32'hFFF0_0000, 32'h0010_0000);
    // settle time below and then at its floor, tick 65536 and then tick 1
    set_regs(32'd0, 32'd200000, 32'd65536);
    send_step(32'h0000_0000, 32'h0100_0000);
    send_step(32'h0050_0000, 32'hFF00_0000);
    set_regs(32'd7, 32'h7FFF_FFFF, 32'd1);
    send_step(32'h0001_0000, 32'hFFFF_0000);
    // tick 65536, then zero tick: position held, velocity kept
    set_regs(32'd30000, 32'h7FFF_FFFF, 32'h0001_0000);
    send_step(32'h0000_0000, 32'h0200_0000);
    set_regs(32'd30000, 32'h7FFF_FFFF, 32'h0002_0000); // bit 17 dropped -> dt 0
    send_step(32'h0000_0000, 32'h0200_0000);
    send_step(32'h0100_0000, 32'h0200_0000);
  endtask

  // follow runs: position fed back toward a moving target, plus noise
  task automatic test_random(int items);
    logic [31:0] cur, tgt;
    int n;
    n = 0;
    cur = $urandom;
    tgt = $urandom;
    while (n < items) begin
      if (n % 250 == 0) begin
        case ($urandom_range(0, 3))
          0: set_regs($urandom_range(7, 300000), $urandom, $urandom_range(0, 65536));
          1: set_regs($urandom, $urandom, $urandom);
          2: set_regs($urandom_range(7, 20), $urandom_range(0, 1000), $urandom_range(1, 4));
          default: set_regs(32'd65536, 32'h7FFF_FFFF, 32'd1092);
        endcase
      end
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 19) == 0) tgt = $urandom;
        else if ($urandom_range(0, 3) == 0) tgt = tgt + $signed($urandom_range(0, 131072)) - 65536;
        send_step(cur, tgt);
        // feed back the predicted position of this step
        cur = last_pred_pos;
      end else begin
        cur = $urandom;
        if ($urandom_range(0, 1)) tgt = $urandom;
        send_step(cur, tgt);
      end
      n++;
    end
  endtask

  // long receiver stall while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        repeat (12) send_step($urandom, $urandom, 0);
      end
    join
    // sender pauses until every result is back, sink never stalls
    wait_drained();
    fast_sink = 1'b1;
    repeat (20) send_step($urandom, $urandom, 0);
    wait_drained();
    fast_sink = 1'b0;
  endtask

  initial begin
    settle_time_q = SETTLE_TIME_RST;
    speed_cap_q = SPEED_CAP_RST;
    tick_period_q = TICK_PERIOD_RST;
    velocity_q = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_backpressure();
    test_random(1900);
    wait_drained();
    $display("run covered %0d results, %0d of them snapped to target", results_seen,
             snaps_seen);
    $display("corners, register extremes, zero tick and a long output stall included");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hdl/sdf_pkg.sv
hdl/sdf_alu.sv
hdl/smooth_damp_follower.sv
tb/sv/testbench.sv
